>>> src/hall_sensor_tachometer_assert.svh
// Assertion macros for the hall sensor tachometer.
`ifndef HALL_SENSOR_TACHOMETER_ASSERT_SVH
`define HALL_SENSOR_TACHOMETER_ASSERT_SVH

// Same-cycle implication.
`define HST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hall_sensor_tachometer: check failed");

// Next-cycle implication.
`define HST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hall_sensor_tachometer: check failed");

`endif

>>> src/hst_pkg.sv
package hst_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int STAMP_W        = 32;
	localparam int CNT_W          = 32;
	localparam int RPM_W          = 26;
	localparam int CFG_W          = 8;
	localparam int CFG_IDX_W      = 2;
	// rpm divisor is saturated to this width; any larger value gives zero rpm
	localparam int DIV_DEN_W      = 27;

	localparam logic [RPM_W-1:0] RPM_NUM = 26'd60000000;

	localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GEAR_REDUCTION = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_RPM_GO,
		ST_RPM_WAIT,
		ST_GEAR_GO,
		ST_GEAR_WAIT,
		ST_OUT
	} tach_state_t;

endpackage

>>> src/hst_hall_if.sv
interface hst_hall_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  sensor_select;
	logic [hst_pkg::STAMP_W-1:0] event_time;
	logic                        level_u;
	logic                        level_v;
	logic                        level_w;

	modport source (
		output valid, sensor_select, event_time, level_u, level_v, level_w,
		input  ready
	);
	modport sink (
		input  valid, sensor_select, event_time, level_u, level_v, level_w,
		output ready
	);
endinterface

>>> src/hst_tach_if.sv
interface hst_tach_if;
	logic                             valid;
	logic                             ready;
	logic                             direction_ccw;
	logic        [hst_pkg::STAMP_W-1:0] edge_interval;
	logic signed [hst_pkg::CNT_W-1:0]   edge_count;
	logic        [hst_pkg::RPM_W-1:0]   motor_rpm;
	logic        [hst_pkg::RPM_W-1:0]   output_rpm;

	modport source (
		output valid, direction_ccw, edge_interval, edge_count, motor_rpm, output_rpm,
		input  ready
	);
	modport sink (
		input  valid, direction_ccw, edge_interval, edge_count, motor_rpm, output_rpm,
		output ready
	);
endinterface

>>> src/hst_cfg_if.sv
interface hst_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [hst_pkg::CFG_IDX_W-1:0] addr;
	logic [hst_pkg::CFG_W-1:0]     data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

>>> src/hst_div.sv
// Restoring divider, two quotient bits per cycle.
module hst_div #(
	parameter int NUM_W = hst_pkg::RPM_W,
	parameter int DEN_W = hst_pkg::DIV_DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [NUM_W-1:0] quotient,
	output logic             done
);
	localparam int STEPS = (NUM_W + 1) / 2;
	localparam int PAD_W = 2 * STEPS;
	localparam int CW    = $clog2(STEPS + 1);

	logic [PAD_W-1:0] num_q;
	logic [PAD_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;

	logic [PAD_W-1:0] num_sh;
	logic [DEN_W-1:0] rem_d;
	logic [DEN_W:0]   trial;
	logic [1:0]       qd;

	always_comb begin
		rem_d  = rem_q;
		num_sh = num_q;
		qd     = '0;
		trial  = '0;
		for (int i = 0; i < 2; i++) begin
			trial  = {rem_d, num_sh[PAD_W-1]};
			num_sh = num_sh << 1;
			if (trial >= {1'b0, den_q}) begin
				trial = trial - {1'b0, den_q};
				qd    = {qd[0], 1'b1};
			end else begin
				qd    = {qd[0], 1'b0};
			end
			rem_d = trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= PAD_W'(dividend);
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= num_sh;
			rem_q <= rem_d;
			quo_q <= {quo_q[PAD_W-3:0], qd};
		end
	end

	assign quotient = quo_q[NUM_W-1:0];
	assign done     = done_q;
endmodule

>>> src/hall_sensor_tachometer.sv
// Hall sensor tachometer for a three-sensor BLDC motor.
// hall (sink): one edge event per request: sensor_select (0 U, 1 W, 2 V),
//   microsecond event_time and the three hall levels. Select 3 updates nothing.
// tach (source): one result per request: direction, the edged sensor's new
//   interval and pulse count, the median motor rpm of the three sensors and
//   that median divided by the gear reduction.
// cfg (sink): register writes, addr 0 pulses_per_rev, addr 1 gear_reduction;
//   always ready, other addresses ignored, 0 acts as 1. Write only while idle.
// Datapath: the three sensor rpm divisions run in parallel lanes, then the gear
//   division; each divider retires two quotient bits per cycle. A new request is
//   taken only in the idle state, once the previous result has been loaded into
//   the output register.
// A result sits in the output register until taken; the next request is
//   accepted and processed meanwhile, and if the result is still not taken
//   the block holds its new result and stops accepting.
// Reset clears all timestamps, intervals and counts, sets direction to
//   clockwise and both registers to 1.
module hall_sensor_tachometer #(
	parameter int TIME_WIDTH = hst_pkg::TIME_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	hst_hall_if.sink   hall,
	hst_tach_if.source tach,
	hst_cfg_if.sink    cfg
);
	localparam int DW   = hst_pkg::DIV_DEN_W;
	localparam int PW   = DW + hst_pkg::CFG_W;
	localparam int RW   = hst_pkg::RPM_W;

	hst_pkg::tach_state_t state_q, state_d;

	logic [hst_pkg::CFG_W-1:0] ppr_q, gear_q;
	logic [hst_pkg::CFG_W-1:0] ppr_eff, gear_eff;

	logic [TIME_WIDTH-1:0]       last_time_q [3];
	logic [TIME_WIDTH-1:0]       intv_q      [3];
	logic [hst_pkg::CNT_W-1:0]   count_q     [3];
	logic                        dir_q;

	logic [hst_pkg::STAMP_W-1:0] pend_ivl_q;
	logic [hst_pkg::CNT_W-1:0]   pend_cnt_q;
	logic [DW-1:0]               den_q [3];
	logic [RW-1:0]               med_q;

	logic                        out_valid_q;
	logic                        out_dir_q;
	logic [hst_pkg::STAMP_W-1:0] out_ivl_q;
	logic [hst_pkg::CNT_W-1:0]   out_cnt_q;
	logic [RW-1:0]               out_mrpm_q;
	logic [RW-1:0]               out_orpm_q;

	logic                        accept;
	logic                        sel_ok;
	logic [1:0]                  idx;
	logic                        own_lvl, nb_lvl, dir_new;
	logic [TIME_WIDTH-1:0]       t_w;
	logic [TIME_WIDTH-1:0]       ivl_new;
	logic [hst_pkg::CNT_W-1:0]   cnt_new;
	logic [PW-1:0]               prod [3];
	logic [2:0]                  sat;

	logic                        rpm_start, gear_start, out_load;
	logic [RW-1:0]               rpm [3];
	logic [2:0]                  rpm_done;
	logic [RW-1:0]               med;
	logic [RW-1:0]               gear_quo;
	logic                        gear_done;

	function automatic logic [RW-1:0] median3(
		input logic [RW-1:0] a,
		input logic [RW-1:0] b,
		input logic [RW-1:0] c
	);
		logic [RW-1:0] lo, hi, m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m  = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction

	// configuration
	assign cfg.ready = 1'b1;
	assign ppr_eff   = (ppr_q == '0) ? hst_pkg::CFG_W'(1) : ppr_q;
	assign gear_eff  = (gear_q == '0) ? hst_pkg::CFG_W'(1) : gear_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q  <= hst_pkg::CFG_W'(1);
			gear_q <= hst_pkg::CFG_W'(1);
		end else if (cfg.valid) begin
			if (cfg.addr == hst_pkg::REG_PULSES_PER_REV) begin
				ppr_q <= cfg.data;
			end else if (cfg.addr == hst_pkg::REG_GEAR_REDUCTION) begin
				gear_q <= cfg.data;
			end
		end
	end

	// edge event: direction, interval and count of the edged sensor
	assign accept  = hall.valid && hall.ready;
	assign sel_ok  = (hall.sensor_select != 2'd3);
	assign idx     = sel_ok ? hall.sensor_select : 2'd0;
	assign t_w     = TIME_WIDTH'(64'(hall.event_time));
	assign ivl_new = t_w - last_time_q[idx];

	always_comb begin
		unique case (hall.sensor_select)
			2'd0: begin
				own_lvl = hall.level_u;
				nb_lvl  = hall.level_w;
			end
			2'd1: begin
				own_lvl = hall.level_w;
				nb_lvl  = hall.level_v;
			end
			2'd2: begin
				own_lvl = hall.level_v;
				nb_lvl  = hall.level_u;
			end
			default: begin
				own_lvl = 1'b0;
				nb_lvl  = 1'b0;
			end
		endcase
	end

	assign dir_new = (own_lvl == nb_lvl);
	assign cnt_new = dir_new ? count_q[idx] - hst_pkg::CNT_W'(1)
	                         : count_q[idx] + hst_pkg::CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				last_time_q[i] <= '0;
				intv_q[i]      <= '0;
				count_q[i]     <= '0;
			end
		end else if (accept && sel_ok) begin
			dir_q            <= dir_new;
			last_time_q[idx] <= t_w;
			intv_q[idx]      <= ivl_new;
			count_q[idx]     <= cnt_new;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_ivl_q <= sel_ok ? hst_pkg::STAMP_W'(64'(ivl_new)) : '0;
			pend_cnt_q <= sel_ok ? cnt_new : '0;
		end
	end

	// rpm divisor per lane: interval * pulses_per_rev, saturated so that
	// zero or oversized intervals yield zero rpm
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = PW'(DW'(intv_q[i])) * PW'(ppr_eff);
			sat[i]  = (intv_q[i] == '0) || ((64'(intv_q[i]) >> DW) != 64'd0)
			          || (prod[i][PW-1:DW] != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == hst_pkg::ST_SCALE) begin
			for (int i = 0; i < 3; i++) begin
				den_q[i] <= sat[i] ? '1 : prod[i][DW-1:0];
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		hst_div #(
			.NUM_W (RW),
			.DEN_W (DW)
		) u_rpm_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (rpm_start),
			.dividend (hst_pkg::RPM_NUM),
			.divisor  (den_q[g]),
			.quotient (rpm[g]),
			.done     (rpm_done[g])
		);
	end

	assign med = median3(rpm[0], rpm[1], rpm[2]);

	always_ff @(posedge clk) begin
		if (gear_start) begin
			med_q <= med;
		end
	end

	hst_div #(
		.NUM_W (RW),
		.DEN_W (hst_pkg::CFG_W)
	) u_gear_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (gear_start),
		.dividend (med),
		.divisor  (gear_eff),
		.quotient (gear_quo),
		.done     (gear_done)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		hall.ready = 1'b0;
		rpm_start  = 1'b0;
		gear_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			hst_pkg::ST_IDLE: begin
				hall.ready = 1'b1;
				if (hall.valid) begin
					state_d = hst_pkg::ST_SCALE;
				end
			end
			hst_pkg::ST_SCALE: begin
				state_d = hst_pkg::ST_RPM_GO;
			end
			hst_pkg::ST_RPM_GO: begin
				rpm_start = 1'b1;
				state_d   = hst_pkg::ST_RPM_WAIT;
			end
			hst_pkg::ST_RPM_WAIT: begin
				if (&rpm_done) begin
					state_d = hst_pkg::ST_GEAR_GO;
				end
			end
			hst_pkg::ST_GEAR_GO: begin
				gear_start = 1'b1;
				state_d    = hst_pkg::ST_GEAR_WAIT;
			end
			hst_pkg::ST_GEAR_WAIT: begin
				if (gear_done) begin
					state_d = hst_pkg::ST_OUT;
				end
			end
			hst_pkg::ST_OUT: begin
				if (!out_valid_q || tach.ready) begin
					out_load = 1'b1;
					state_d  = hst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hst_pkg::ST_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (tach.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_dir_q  <= dir_q;
			out_ivl_q  <= pend_ivl_q;
			out_cnt_q  <= pend_cnt_q;
			out_mrpm_q <= med_q;
			out_orpm_q <= gear_quo;
		end
	end

	assign tach.valid         = out_valid_q;
	assign tach.direction_ccw = out_dir_q;
	assign tach.edge_interval = out_ivl_q;
	assign tach.edge_count    = signed'(out_cnt_q);
	assign tach.motor_rpm     = out_mrpm_q;
	assign tach.output_rpm    = out_orpm_q;

`include "hall_sensor_tachometer_assert.svh"

	`HST_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, state_q == hst_pkg::ST_SCALE)
	`HST_ASSERT_NOW(a_rpm_done_wait, clk, arst_n, rpm_done[0], state_q == hst_pkg::ST_RPM_WAIT)
	`HST_ASSERT_NOW(a_gear_done_wait, clk, arst_n, gear_done, state_q == hst_pkg::ST_GEAR_WAIT)
	`HST_ASSERT_NOW(a_gear_not_above, clk, arst_n, out_valid_q, out_orpm_q <= out_mrpm_q)

endmodule

>>> dv/hall_sensor_tachometer_test.sv
`timescale 1ns / 1ps

module hall_sensor_tachometer_test;

	localparam logic [1:0] SEL_U    = 2'd0;
	localparam logic [1:0] SEL_W    = 2'd1;
	localparam logic [1:0] SEL_V    = 2'd2;
	localparam logic [1:0] SEL_NONE = 2'd3;

	// addresses past the register list, writes there must change nothing
	localparam logic [hst_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [hst_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [63:0] US_PER_MINUTE = 64'd60000000;
	localparam int ITEM_TARGET     = 1150;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 40;
	localparam int LIMIT_CYCLES    = 600000;
	localparam int MAX_REPORTS     = 40;

	typedef struct packed {
		logic                             ccw;
		logic [hst_pkg::STAMP_W-1:0]      interval;
		logic signed [hst_pkg::CNT_W-1:0] count;
		logic [hst_pkg::RPM_W-1:0]        motor;
		logic [hst_pkg::RPM_W-1:0]        geared;
	} tach_result_t;

	logic clk;
	logic arst_n;

	hst_hall_if hall_bus ();
	hst_tach_if tach_bus ();
	hst_cfg_if  cfg_bus ();

	hall_sensor_tachometer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hall   (hall_bus),
		.tach   (tach_bus),
		.cfg    (cfg_bus)
	);

	// predictor state, reset values
	logic [hst_pkg::CFG_W-1:0]   cfg_ppr  = 8'd1;
	logic [hst_pkg::CFG_W-1:0]   cfg_gear = 8'd1;
	logic [hst_pkg::STAMP_W-1:0] edge_stamp [3]      = '{default: '0};
	logic [hst_pkg::STAMP_W-1:0] sensor_interval [3] = '{default: '0};
	logic [hst_pkg::CNT_W-1:0]   sensor_count [3]    = '{default: '0};
	logic                        ccw_flag = 1'b0;

	tach_result_t tach_expected [$];

	int  mismatch_count = 0;
	int  items_sent     = 0;
	int  burst_left     = 0;
	bit  hold_off_req   = 0;

	logic [hst_pkg::STAMP_W-1:0] rot_stamp  = '0;
	int                          rot_sensor = 0;
	logic                        rot_ccw    = 1'b0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	function automatic logic [hst_pkg::RPM_W-1:0] rpm_of(
			logic [hst_pkg::STAMP_W-1:0] interval, logic [hst_pkg::CFG_W-1:0] ppr);
		logic [63:0] q;
		if (interval == '0)
			return '0;
		q = US_PER_MINUTE / interval;
		q = q / ((ppr == '0) ? 8'd1 : ppr);
		return q[hst_pkg::RPM_W-1:0];
	endfunction

	function automatic logic [hst_pkg::RPM_W-1:0] median_of3(
			logic [hst_pkg::RPM_W-1:0] a, b, c);
		logic [hst_pkg::RPM_W-1:0] lo, hi, m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m  = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction

	// advances the tachometer state by one hall edge
	function automatic tach_result_t predict_tach(logic [1:0] sel,
			logic [hst_pkg::STAMP_W-1:0] stamp, logic lu, logic lv, logic lw);
		tach_result_t r;
		logic own, nb;
		logic [hst_pkg::RPM_W-1:0] rpm [3];
		r = '0;
		if (sel != SEL_NONE) begin
			// neighbor pairs: U-W, W-V, V-U
			case (sel)
				SEL_U: begin own = lu; nb = lw; end
				SEL_W: begin own = lw; nb = lv; end
				default:  begin own = lv; nb = lu; end
			endcase
			ccw_flag = (own == nb);
			r.interval = stamp - edge_stamp[sel];
			sensor_interval[sel] = r.interval;
			edge_stamp[sel] = stamp;
			if (ccw_flag)
				sensor_count[sel] = sensor_count[sel] - 1;
			else
				sensor_count[sel] = sensor_count[sel] + 1;
			r.count = sensor_count[sel];
		end
		r.ccw = ccw_flag;
		for (int i = 0; i < 3; i++)
			rpm[i] = rpm_of(sensor_interval[i], cfg_ppr);
		r.motor  = median_of3(rpm[0], rpm[1], rpm[2]);
		r.geared = r.motor / ((cfg_gear == '0) ? 8'd1 : cfg_gear);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want)
			report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
	endtask

	// request tracking, result checking, register tracking
	always @(posedge clk) begin
		tach_result_t want;
		if (arst_n) begin
			if (tach_bus.valid === 1'b1 && tach_bus.ready === 1'b1) begin
				if (tach_expected.size() == 0) begin
					report_mismatch("result with no request pending");
				end else begin
					want = tach_expected.pop_front();
					check_field("direction_ccw", want.ccw, tach_bus.direction_ccw);
					check_field("edge_interval", want.interval, tach_bus.edge_interval);
					check_field("edge_count", want.count, tach_bus.edge_count);
					check_field("motor_rpm", want.motor, tach_bus.motor_rpm);
					check_field("output_rpm", want.geared, tach_bus.output_rpm);
				end
			end
			if (hall_bus.valid === 1'b1 && hall_bus.ready === 1'b1)
				tach_expected.push_back(predict_tach(hall_bus.sensor_select,
					hall_bus.event_time, hall_bus.level_u, hall_bus.level_v,
					hall_bus.level_w));
			if (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1) begin
				if (cfg_bus.addr == hst_pkg::REG_PULSES_PER_REV)
					cfg_ppr = cfg_bus.data;
				else if (cfg_bus.addr == hst_pkg::REG_GEAR_REDUCTION)
					cfg_gear = cfg_bus.data;
			end
		end
	end

	// result side: random open/stall runs, plus a long hold-off on request
	initial begin
		bit rx_open;
		int run_left;
		rx_open = 1'b0;
		run_left = 0;
		tach_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				tach_bus.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 0;
			end else begin
				if (run_left == 0) begin
					rx_open = !rx_open;
					if (rx_open)
						run_left = $urandom_range(1, 60);
					else if ($urandom_range(0, 3) == 0)
						run_left = $urandom_range(20, 45);
					else
						run_left = $urandom_range(1, 6);
				end
				run_left--;
				tach_bus.ready <= rx_open;
			end
		end
	end

	task automatic send_edge(input logic [1:0] sel, input logic [hst_pkg::STAMP_W-1:0] stamp,
			input logic lu, input logic lv, input logic lw);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			else if ($urandom_range(0, 4) == 0)
				gap = $urandom_range(9, 45);
			else
				gap = $urandom_range(1, 8);
			if (gap > 0) begin
				hall_bus.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		hall_bus.valid         <= 1'b1;
		hall_bus.sensor_select <= sel;
		hall_bus.event_time    <= stamp;
		hall_bus.level_u       <= lu;
		hall_bus.level_v       <= lv;
		hall_bus.level_w       <= lw;
		do @(posedge clk); while (hall_bus.ready !== 1'b1);
		items_sent++;
	endtask

	task automatic hall_release;
		@(negedge clk);
		hall_bus.valid <= 1'b0;
	endtask

	task automatic wait_drained;
		while (tach_expected.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [hst_pkg::CFG_IDX_W-1:0] idx,
			input logic [hst_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.addr  <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [hst_pkg::CFG_W-1:0] ppr,
			input logic [hst_pkg::CFG_W-1:0] gear);
		hall_release();
		wait_drained();
		write_reg(hst_pkg::REG_PULSES_PER_REV, ppr);
		write_reg(hst_pkg::REG_GEAR_REDUCTION, gear);
	endtask

	function automatic logic [hst_pkg::CFG_W-1:0] pick_reg_value;
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd255;
			3: return 8'($urandom_range(2, 8));
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [hst_pkg::STAMP_W-1:0] pick_step(input int scale);
		case (scale)
			0: return $urandom_range(0, 3);
			1: return $urandom_range(1, 200);
			2: return $urandom_range(200, 60000);
			3: return $urandom_range(60000, 80000000);
			default: return $urandom;
		endcase
	endfunction

	// edge on the given sensor with the neighbor level set for the direction
	task automatic send_rotating(input logic [1:0] sel, input logic [hst_pkg::STAMP_W-1:0] stamp,
			input logic ccw);
		logic lu, lv, lw;
		{lu, lv, lw} = 3'($urandom_range(0, 7));
		case (sel)
			SEL_U: lw = ccw ? lu : ~lu;
			SEL_W: lv = ccw ? lw : ~lw;
			default:  lu = ccw ? lv : ~lv;
		endcase
		send_edge(sel, stamp, lu, lv, lw);
	endtask

	// a spinning motor at one speed range, with some junk edges mixed in
	task automatic run_rotation(input int n);
		int scale;
		scale = $urandom_range(0, 4);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				send_edge(2'($urandom_range(0, 3)), $urandom, 1'($urandom),
					1'($urandom), 1'($urandom));
			end else begin
				rot_stamp = rot_stamp + pick_step(scale);
				rot_sensor = (rot_sensor + (rot_ccw ? 2 : 1)) % 3;
				if ($urandom_range(0, 15) == 0)
					rot_ccw = ~rot_ccw;
				send_rotating(2'(rot_sensor), rot_stamp, rot_ccw);
			end
		end
	endtask

	task automatic test_directed_edges;
		// register defaults after reset, nothing written yet
		send_edge(SEL_NONE, 32'd0, 1'b0, 1'b0, 1'b0);
		send_edge(SEL_U, 32'd0, 1'b1, 1'b0, 1'b0);
		send_edge(SEL_W, 32'd1, 1'b0, 1'b1, 1'b0);
		// one-microsecond intervals on two sensors: top rpm as the median
		send_edge(SEL_U, 32'd1, 1'b1, 1'b0, 1'b0);
		send_edge(SEL_W, 32'd2, 1'b0, 1'b1, 1'b0);
		send_edge(SEL_V, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
		// timestamp wrap
		send_edge(SEL_V, 32'd4, 1'b1, 1'b1, 1'b1);
		// zero interval, counter-clockwise
		send_edge(SEL_U, 32'd1, 1'b1, 1'b0, 1'b1);
		// drive one count negative
		repeat (4) send_edge(SEL_W, 32'd2, 1'b0, 1'b0, 1'b0);
		send_edge(SEL_NONE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
		for (int k = 0; k < 8; k++)
			send_edge(2'(k % 3), 32'd100 + 32'(k) * 32'd997, k[0], k[1], k[2]);
		send_edge(SEL_NONE, 32'h5555_AAAA, 1'b0, 1'b1, 1'b0);
	endtask

	task automatic test_register_settings;
		apply_settings(8'd255, 8'd255);
		run_rotation(25);
		apply_settings(8'd0, 8'd0);
		run_rotation(25);
		apply_settings(8'd1, 8'd255);
		run_rotation(25);
		apply_settings(8'd255, 8'd1);
		run_rotation(25);
		apply_settings(8'($urandom_range(2, 20)), 8'($urandom_range(2, 20)));
		run_rotation(20);
		hall_release();
		wait_drained();
		write_reg(REG_SPARE_2, 8'($urandom));
		write_reg(REG_SPARE_3, 8'($urandom));
		run_rotation(15);
	endtask

	// long result stall so the block backs up and refuses requests
	task automatic test_input_stall;
		hall_release();
		wait_drained();
		hold_off_req = 1;
		run_rotation(12);
	endtask

	task automatic test_random_rotation;
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 3) == 0)
				apply_settings(pick_reg_value(), pick_reg_value());
			run_rotation($urandom_range(10, 40));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		hall_bus.valid = 1'b0;
		hall_bus.sensor_select = '0;
		hall_bus.event_time = '0;
		hall_bus.level_u = 1'b0;
		hall_bus.level_v = 1'b0;
		hall_bus.level_w = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.addr = '0;
		cfg_bus.data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_edges();
		test_register_settings();
		test_input_stall();
		test_random_rotation();

		hall_release();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tach_expected.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", tach_expected.size()));
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
